[hw/rtl/sha384_pkg.sv]
// sha384_pkg: payload and queue types, sha-384 initial values, round constants
// and the sha-512 bit functions shared by the hash engine modules
// depends on nothing
package sha384_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] FULL_WORD_BYTES = 4'd8;
  localparam logic [6:0] LENGTH_POS      = 7'd112;
  localparam logic [7:0] BLOCK_BYTES     = 8'd128;
  localparam logic [7:0] PAD_BYTE        = 8'h80;
  localparam logic [6:0] LAST_ROUND      = 7'd79;
  localparam logic [2:0] LAST_DIGEST_IDX = 3'd5;

  typedef struct packed {
    logic [63:0] message_word;
    logic [3:0]  byte_count;
    logic        last_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
  } dig_item_t;

  // request as it travels through the queue, byte count already clamped
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [63:0] init_value(input logic [2:0] idx);
    logic [63:0] v;
    case (idx)
      3'd0: v = 64'hcbbb9d5dc1059ed8;
      3'd1: v = 64'h629a292a367cd507;
      3'd2: v = 64'h9159015a3070dd17;
      3'd3: v = 64'h152fecd8f70e5939;
      3'd4: v = 64'h67332667ffc00b31;
      3'd5: v = 64'h8eb44a8768581511;
      3'd6: v = 64'hdb0c2e0d64f98fa7;
      3'd7: v = 64'h47b5481dbefa4fa4;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] round_const(input logic [6:0] idx);
    logic [63:0] k;
    case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'd0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

[hw/rtl/sha384_front.sv]
// sha384_front: input stage, takes message requests, clamps the byte count
// and hands them to the queue; depends on sha384_pkg
module sha384_front
  import sha384_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_ready,
  input  msg_item_t msg,
  input  q_stat_t   q_stat,
  output logic      push,
  output cmd_t      push_cmd
);

  logic hold_valid;
  cmd_t hold;

  assign push      = hold_valid & ~q_stat.full;
  assign msg_ready = ~hold_valid | ~q_stat.full;
  assign push_cmd  = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (msg_valid && msg_ready) begin
      hold_valid <= 1'b1;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_valid && msg_ready) begin
      hold.word  <= msg.message_word;
      hold.count <= (msg.byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : msg.byte_count;
      hold.last  <= msg.last_of_message;
    end
  end

endmodule

[hw/rtl/sha384_queue.sv]
// sha384_queue: short request queue between front and back parts
// depends on sha384_pkg
module sha384_queue
  import sha384_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t q_stat
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_cmd      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hw/rtl/sha384_back.sv]
// sha384_back: byte packing, padding, 80-round compression and digest output
// depends on sha384_pkg
module sha384_back
  import sha384_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  q_stat_t   q_stat,
  input  cmd_t      pop_cmd,
  output logic      pop,
  output logic      dig_valid,
  input  logic      dig_ready,
  output dig_item_t dig
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INSERT = 3'd1;
  localparam logic [2:0] S_PAD    = 3'd2;
  localparam logic [2:0] S_LEN    = 3'd3;
  localparam logic [2:0] S_INIT   = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_ADD    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]   state;
  logic [2:0]   ret;
  logic [6:0]   fill;
  logic [127:0] byte_len;
  logic [63:0]  pend_word;
  logic [3:0]   pend_cnt;
  logic         pend_last;
  logic [6:0]   rnd;
  logic [2:0]   out_idx;
  logic [63:0]  chain [8];
  logic [63:0]  blk [16];
  logic [63:0]  v [8];
  logic [63:0]  hkw;

  logic [7:0]   room;
  logic [3:0]   take;
  logic [63:0]  lead_mask;
  logic [127:0] ins_data;
  logic [127:0] ins_mask;
  logic [7:0]   fill_sum;
  logic [3:0]   wsel;
  logic [3:0]   wsel_nx;
  logic [63:0]  pad_blk [16];
  logic [127:0] bit_len;
  logic [63:0]  t1;
  logic [63:0]  t2;
  logic [63:0]  w_new;
  logic [6:0]   rnd_nx;
  logic         dig_load;

  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign dig_load = (state == S_OUT) && (!dig_valid || dig_ready);

  always_comb begin
    room      = BLOCK_BYTES - {1'b0, fill};
    take      = ({4'd0, pend_cnt} > room) ? room[3:0] : pend_cnt;
    lead_mask = ~({64{1'b1}} >> {take, 3'b000});
    ins_data  = {pend_word & lead_mask, 64'd0} >> {fill[2:0], 3'b000};
    ins_mask  = {lead_mask, 64'd0} >> {fill[2:0], 3'b000};
    fill_sum  = {1'b0, fill} + {4'd0, take};
    wsel      = fill[6:3];
    wsel_nx   = wsel + 4'd1;
    bit_len   = {byte_len[124:0], 3'b000};
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 8; j++) begin
        if (7'(i * 8 + j) == fill) begin
          pad_blk[i][63-8*j -: 8] = PAD_BYTE;
        end else if (7'(i * 8 + j) > fill) begin
          pad_blk[i][63-8*j -: 8] = 8'd0;
        end else begin
          pad_blk[i][63-8*j -: 8] = blk[i][63-8*j -: 8];
        end
      end
    end
    t1     = hkw + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]));
    t2     = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new  = small_sigma1(blk[14]) + blk[9] + small_sigma0(blk[1]) + blk[0];
    rnd_nx = rnd + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      fill      <= '0;
      byte_len  <= '0;
      out_idx   <= '0;
      dig_valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= init_value(3'(i));
      end
    end else begin
      if (dig_load) begin
        dig_valid <= 1'b1;
      end else if (dig_ready) begin
        dig_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            byte_len <= byte_len + {124'd0, pop_cmd.count};
            state    <= S_INSERT;
          end
        end
        S_INSERT: begin
          fill <= fill_sum[6:0];
          if (fill_sum[7]) begin
            ret   <= S_INSERT;
            state <= S_INIT;
          end else if (pend_last) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PAD: begin
          fill  <= '0;
          ret   <= (fill < LENGTH_POS) ? S_OUT : S_LEN;
          state <= S_INIT;
        end
        S_LEN: begin
          ret   <= S_OUT;
          state <= S_INIT;
        end
        S_INIT: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          if (rnd == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          state <= ret;
        end
        S_OUT: begin
          if (dig_load) begin
            if (out_idx == LAST_DIGEST_IDX) begin
              out_idx  <= '0;
              fill     <= '0;
              byte_len <= '0;
              state    <= S_IDLE;
              for (int i = 0; i < 8; i++) begin
                chain[i] <= init_value(3'(i));
              end
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        pend_word <= pop_cmd.word;
        pend_cnt  <= pop_cmd.count;
        pend_last <= pop_cmd.last;
      end
      S_INSERT: begin
        blk[wsel] <= (blk[wsel] & ~ins_mask[127:64]) | ins_data[127:64];
        if (wsel != 4'd15) begin
          blk[wsel_nx] <= (blk[wsel_nx] & ~ins_mask[63:0]) | ins_data[63:0];
        end
        pend_word <= pend_word << {take, 3'b000};
        pend_cnt  <= pend_cnt - take;
      end
      S_PAD: begin
        for (int i = 0; i < 14; i++) begin
          blk[i] <= pad_blk[i];
        end
        blk[14] <= (fill < LENGTH_POS) ? bit_len[127:64] : pad_blk[14];
        blk[15] <= (fill < LENGTH_POS) ? bit_len[63:0] : pad_blk[15];
      end
      S_LEN: begin
        for (int i = 0; i < 14; i++) begin
          blk[i] <= 64'd0;
        end
        blk[14] <= bit_len[127:64];
        blk[15] <= bit_len[63:0];
      end
      S_INIT: begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= chain[i];
        end
        hkw <= chain[7] + round_const(7'd0) + blk[0];
        rnd <= '0;
      end
      S_ROUND: begin
        v[0] <= t1 + t2;
        v[1] <= v[0];
        v[2] <= v[1];
        v[3] <= v[2];
        v[4] <= v[3] + t1;
        v[5] <= v[4];
        v[6] <= v[5];
        v[7] <= v[6];
        // next round's h + k + w, computed during the current round
        hkw <= v[6] + round_const(rnd_nx) + blk[1];
        for (int i = 0; i < 15; i++) begin
          blk[i] <= blk[i+1];
        end
        blk[15] <= w_new;
        rnd     <= rnd_nx;
      end
      S_OUT: begin
        if (dig_load) begin
          dig.digest_word <= chain[out_idx];
          dig.word_index  <= out_idx;
          dig.digest_done <= (out_idx == LAST_DIGEST_IDX);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/sha384_hash_engine.sv]
// sha384_hash_engine: top level, front stage, request queue and hashing back end
// depends on sha384_pkg, sha384_front, sha384_queue, sha384_back
//
//   channel   signals                      payload
//   request   msg_valid / msg_ready        msg : msg_item_t (word, byte count, last)
//   digest    dig_valid / dig_ready        dig : dig_item_t (word, index, done)
//
// a word passes the back end in a fetch step and a byte insert step; a word that fills a
// block adds a load, 80 rounds of the single round unit, a chain add and an insert;
// the last word adds a pad step, one block (or a length step and a second block),
// and the output of the six digest words
// the queue lets requests come in while a block is compressed, until it is full; a
// stalled digest holds the back end in its output step only
// synchronous active-high reset restores initial chain, length and fill at once
module sha384_hash_engine
  import sha384_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_ready,
  input  msg_item_t msg,
  output logic      dig_valid,
  input  logic      dig_ready,
  output dig_item_t dig
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;

  sha384_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  sha384_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  sha384_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

endmodule
